// File: hdl/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter package
// Shared widths, payload types and constant-divide coefficients.
// ----------------------------------------------------------------------------
package tmwf_pkg;

    // Port widths are fixed by the channel definitions.
    localparam int SAMPLE_PORT_W = 32;
    localparam int FILT_W        = 32;
    localparam int FILL_W        = 3;

    // Significant sample width; upper port bits are ignored.
    localparam int SAMPLE_BITS   = 32;

    localparam int WIN_LEN       = 5;
    localparam int TRIM_MIN      = 3;
    localparam int SLOT_W        = $clog2(WIN_LEN);

    // Sum of five samples, sum of three after trimming, and its magnitude.
    localparam int SUM_W         = SAMPLE_BITS + 3;
    localparam int TRIM_W        = SAMPLE_BITS + 2;
    localparam int MAG_W         = SAMPLE_BITS + 1;

    // Divide by three in two halves: high part first, then remainder:low part.
    localparam int HI_W          = MAG_W / 2;
    localparam int LO_W          = MAG_W - HI_W;
    localparam int QH_W          = HI_W - 1;
    localparam int X_W           = LO_W + 2;
    localparam int KH            = HI_W + 1;
    localparam int KL            = LO_W + 3;
    localparam logic [HI_W-1:0] RECIP_HI = HI_W'(((2 ** KH) + 2) / 3);
    localparam logic [X_W-1:0]  RECIP_LO = X_W'(((2 ** KL) + 2) / 3);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [FILL_W-1:0]             fill_t;

    typedef enum logic [1:0] {
        DIV_1 = 2'd0,
        DIV_2 = 2'd1,
        DIV_3 = 2'd2
    } div_sel_t;

    // Snapshot of the window after one transaction.
    typedef struct packed {
        sample_t [WIN_LEN-1:0] smp;
        fill_t                 fill;
    } win_t;

    // Trimmed sum ready for division.
    typedef struct packed {
        logic signed [TRIM_W-1:0] trim;
        fill_t                    fill;
    } trim_t;

endpackage

// File: hdl/tmwf_if.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter channels
// Valid/ready channels for the sample input and the filtered result.
// ----------------------------------------------------------------------------
interface tmwf_in_if
    import tmwf_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [SAMPLE_PORT_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmwf_out_if
    import tmwf_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [FILT_W-1:0] filtered;
    logic [FILL_W-1:0]        window_fill;

    modport source (output valid, output filtered, output window_fill, input ready);
    modport sink   (input valid, input filtered, input window_fill, output ready);
endinterface

// File: hdl/tmwf_window.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter: sample ring
// Holds the five-entry ring, write slot and fill count; registers a snapshot.
// ----------------------------------------------------------------------------
module tmwf_window
    import tmwf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tmwf_in_if.sink  sample_ch,
    output logic     win_valid,
    input  logic     win_ready,
    output win_t     win
);

    sample_t [WIN_LEN-1:0] ring_reg;
    logic [SLOT_W-1:0]     slot_reg;
    fill_t                 fill_reg;

    logic                  s1_valid_reg;
    sample_t [WIN_LEN-1:0] s1_smp_reg;
    fill_t                 s1_fill_reg;

    logic                  s1_ready;
    logic                  accept;
    sample_t               sample_next;
    sample_t [WIN_LEN-1:0] ring_next;
    logic [SLOT_W-1:0]     slot_next;
    fill_t                 fill_next;

    assign s1_ready        = !s1_valid_reg || win_ready;
    assign sample_ch.ready = s1_ready;
    assign accept          = sample_ch.valid && s1_ready;
    assign sample_next     = sample_t'(sample_ch.sample[SAMPLE_BITS-1:0]);

    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            ring_next[i] = (slot_reg == SLOT_W'(i)) ? sample_next : ring_reg[i];
        end
        slot_next = (slot_reg == SLOT_W'(WIN_LEN - 1)) ? '0 : slot_reg + SLOT_W'(1);
        fill_next = (fill_reg == FILL_W'(WIN_LEN)) ? fill_reg : fill_reg + FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg     <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ring_reg <= ring_next;
                slot_reg <= slot_next;
                fill_reg <= fill_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= sample_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_smp_reg  <= ring_next;
            s1_fill_reg <= fill_next;
        end
    end

    assign win_valid = s1_valid_reg;
    assign win.smp   = s1_smp_reg;
    assign win.fill  = s1_fill_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < SLOT_W'(WIN_LEN))
        else $error("write slot out of range");

    a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < FILL_W'(WIN_LEN)) |-> (slot_reg == SLOT_W'(fill_reg)))
        else $error("write slot and fill count disagree while filling");

    a_snapshot_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((s1_fill_reg == fill_reg) && (fill_reg != '0)))
        else $error("snapshot fill count does not match window state");

endmodule

// File: hdl/tmwf_stats.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter: window statistics
// Sums the held samples, finds the extremes, and removes them when trimming.
// ----------------------------------------------------------------------------
module tmwf_stats
    import tmwf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  win_valid,
    output logic  win_ready,
    input  win_t  win,
    output logic  trim_valid,
    input  logic  trim_ready,
    output trim_t trim
);

    logic                    s2_valid_reg;
    logic signed [SUM_W-1:0] sum_reg;
    sample_t                 lo_reg;
    sample_t                 hi_reg;
    fill_t                   s2_fill_reg;

    logic                     s3_valid_reg;
    logic signed [TRIM_W-1:0] trim_reg;
    fill_t                    s3_fill_reg;

    logic                    s2_ready;
    logic                    s3_ready;
    logic signed [SUM_W-1:0] sum_next;
    sample_t                 lo_next;
    sample_t                 hi_next;
    logic signed [SUM_W-1:0] trim_next;

    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s3_ready  = !s3_valid_reg || trim_ready;
    assign win_ready = s2_ready;

    // Only slots below the fill count are held; slot 0 always is.
    always_comb
    begin
        sum_next = SUM_W'(win.smp[0]);
        lo_next  = win.smp[0];
        hi_next  = win.smp[0];
        for (int i = 1; i < WIN_LEN; i++)
        begin
            if (FILL_W'(i) < win.fill)
            begin
                sum_next = sum_next + SUM_W'(win.smp[i]);
                if (win.smp[i] < lo_next)
                begin
                    lo_next = win.smp[i];
                end
                if (win.smp[i] > hi_next)
                begin
                    hi_next = win.smp[i];
                end
            end
        end
    end

    // Drop one copy of each extreme once three or more are held.
    always_comb
    begin
        if (s2_fill_reg >= FILL_W'(TRIM_MIN))
        begin
            trim_next = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
        end
        else
        begin
            trim_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= win_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && win_valid)
        begin
            sum_reg     <= sum_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            s2_fill_reg <= win.fill;
        end
        if (s3_ready && s2_valid_reg)
        begin
            trim_reg    <= trim_next[TRIM_W-1:0];
            s3_fill_reg <= s2_fill_reg;
        end
    end

    assign trim_valid = s3_valid_reg;
    assign trim.trim  = trim_reg;
    assign trim.fill  = s3_fill_reg;

endmodule

// File: hdl/tmwf_div.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter: divider
// Divides the trimmed sum by 1, 2 or 3 toward zero and holds the result.
// ----------------------------------------------------------------------------
module tmwf_div
    import tmwf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      trim_valid,
    output logic      trim_ready,
    input  trim_t     trim,
    tmwf_out_if.source result_ch
);

    // Stage 4: magnitude and sign.
    logic             v4_reg;
    logic [MAG_W-1:0] mag4_reg;
    logic             neg4_reg;
    div_sel_t         div4_reg;
    fill_t            fill4_reg;

    // Stage 5: high-part quotient.
    logic             v5_reg;
    logic [QH_W-1:0]  qh5_reg;
    logic [MAG_W-1:0] mag5_reg;
    logic             neg5_reg;
    div_sel_t         div5_reg;
    fill_t            fill5_reg;

    // Stage 6: remainder joined with low part.
    logic             v6_reg;
    logic [X_W-1:0]   x6_reg;
    logic [QH_W-1:0]  qh6_reg;
    logic [MAG_W-1:0] mag6_reg;
    logic             neg6_reg;
    div_sel_t         div6_reg;
    fill_t            fill6_reg;

    // Stage 7: low-part quotient.
    logic             v7_reg;
    logic [LO_W-1:0]  q27_reg;
    logic [QH_W-1:0]  qh7_reg;
    logic [MAG_W-1:0] mag7_reg;
    logic             neg7_reg;
    div_sel_t         div7_reg;
    fill_t            fill7_reg;

    // Stage 8: result register.
    logic             v8_reg;
    sample_t          res8_reg;
    fill_t            fill8_reg;

    logic rdy4;
    logic rdy5;
    logic rdy6;
    logic rdy7;
    logic rdy8;

    logic [TRIM_W-1:0]   abs4_next;
    div_sel_t            div4_next;
    logic [2*HI_W-1:0]   prodh_next;
    logic [HI_W-1:0]     mh6;
    logic [HI_W-1:0]     rem6_next;
    logic [2*X_W-1:0]    prodl_next;
    logic [SAMPLE_BITS-1:0] absr_next;
    sample_t             res8_next;

    assign rdy8       = !v8_reg || result_ch.ready;
    assign rdy7       = !v7_reg || rdy8;
    assign rdy6       = !v6_reg || rdy7;
    assign rdy5       = !v5_reg || rdy6;
    assign rdy4       = !v4_reg || rdy5;
    assign trim_ready = rdy4;

    always_comb
    begin
        abs4_next = trim.trim[TRIM_W-1] ? -trim.trim : trim.trim;
        case (trim.fill)
            FILL_W'(2), FILL_W'(4): div4_next = DIV_2;
            FILL_W'(5):             div4_next = DIV_3;
            default:                div4_next = DIV_1;
        endcase
    end

    assign prodh_next = (2*HI_W)'(mag4_reg[MAG_W-1:LO_W]) * (2*HI_W)'(RECIP_HI);

    // Remainder of the high part is below three: two bits suffice.
    assign mh6       = mag5_reg[MAG_W-1:LO_W];
    assign rem6_next = mh6 - (HI_W'({qh5_reg, 1'b0}) + HI_W'(qh5_reg));

    assign prodl_next = (2*X_W)'(x6_reg) * (2*X_W)'(RECIP_LO);

    always_comb
    begin
        case (div7_reg)
            DIV_1:   absr_next = mag7_reg[SAMPLE_BITS-1:0];
            DIV_2:   absr_next = mag7_reg[SAMPLE_BITS:1];
            DIV_3:   absr_next = {qh7_reg, q27_reg};
            default: absr_next = mag7_reg[SAMPLE_BITS-1:0];
        endcase
        res8_next = neg7_reg ? sample_t'(-absr_next) : sample_t'(absr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= trim_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
            if (rdy8)
            begin
                v8_reg <= v7_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && trim_valid)
        begin
            mag4_reg  <= abs4_next[MAG_W-1:0];
            neg4_reg  <= trim.trim[TRIM_W-1];
            div4_reg  <= div4_next;
            fill4_reg <= trim.fill;
        end
        if (rdy5 && v4_reg)
        begin
            qh5_reg   <= prodh_next[KH+QH_W-1:KH];
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            div5_reg  <= div4_reg;
            fill5_reg <= fill4_reg;
        end
        if (rdy6 && v5_reg)
        begin
            x6_reg    <= {rem6_next[1:0], mag5_reg[LO_W-1:0]};
            qh6_reg   <= qh5_reg;
            mag6_reg  <= mag5_reg;
            neg6_reg  <= neg5_reg;
            div6_reg  <= div5_reg;
            fill6_reg <= fill5_reg;
        end
        if (rdy7 && v6_reg)
        begin
            q27_reg   <= prodl_next[KL+LO_W-1:KL];
            qh7_reg   <= qh6_reg;
            mag7_reg  <= mag6_reg;
            neg7_reg  <= neg6_reg;
            div7_reg  <= div6_reg;
            fill7_reg <= fill6_reg;
        end
        if (rdy8 && v7_reg)
        begin
            res8_reg  <= res8_next;
            fill8_reg <= fill7_reg;
        end
    end

    assign result_ch.valid       = v8_reg;
    assign result_ch.filtered    = FILT_W'(res8_reg);
    assign result_ch.window_fill = fill8_reg;

    a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
        v8_reg |-> ((fill8_reg != '0) && (fill8_reg <= FILL_W'(WIN_LEN))))
        else $error("result carries an impossible fill count");

endmodule

// File: hdl/trimmed_mean_window_filter_core.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter core
// Five-point window: plain mean below three samples, else drop one largest
// and one smallest and average the rest, truncated toward zero.
// ----------------------------------------------------------------------------
//
//   Channel     Dir   Payload                         Transaction
//   sample_ch   in    sample[31:0]                    valid && ready
//   result_ch   out   filtered[31:0], window_fill[2:0] valid && ready
//
// One transaction can be taken every cycle while the result channel keeps up;
// each produces exactly one result after eight register stages: window
// snapshot, sum and extremes, trim, magnitude, then a divide by three split
// into two reciprocal multiplies, and the result register.
// Each stage advances whenever its successor is empty or advancing, so
// bubbles collapse; while a result waits, input keeps flowing until all eight
// stages hold a transaction, and then the sample channel stalls.
// Reset clears the ring, write slot, fill count and all stage valid bits.
//
module trimmed_mean_window_filter_core
    import tmwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tmwf_in_if.sink    sample_ch,
    tmwf_out_if.source result_ch
);

    // Window snapshot between the ring and the statistics stages.
    logic  win_valid;
    logic  win_ready;
    win_t  win;

    // Trimmed sum between the statistics stages and the divider.
    logic  trim_valid;
    logic  trim_ready;
    trim_t trim;

    // Write each sample into the ring and capture the window it forms.
    tmwf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win)
    );

    // Sum the held samples and drop the extremes when at least three are held.
    tmwf_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win        (win),
        .trim_valid (trim_valid),
        .trim_ready (trim_ready),
        .trim       (trim)
    );

    // Divide by the number of samples kept and hold the result for the sink.
    tmwf_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .trim_valid (trim_valid),
        .trim_ready (trim_ready),
        .trim       (trim),
        .result_ch  (result_ch)
    );

endmodule
